// File: sv/rcp_pkg.sv
// Shared definitions for the rectangle canvas painter.
// Holds request, status and register codes, the rectangle bounds type and the side clamp.
// No dependencies.
package rcp_pkg;

	// Default canvas side in cells.
	localparam int unsigned MAX_SIDE_DEF = 256;

	// Width of the signed fixed-point coordinates used in the coverage compare.
	localparam int unsigned COORD_W = 20;

	// Width of a clamped canvas side (holds up to 1024).
	localparam int unsigned SIDE_W = 11;

	// One unit in fixed point with 8 fraction bits.
	localparam int FRAC_ONE = 256;

	// Request codes.
	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_DRAW  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Status codes.
	localparam logic [1:0] STS_OK         = 2'd0;
	localparam logic [1:0] STS_REJECT     = 2'd1;
	localparam logic [1:0] STS_OFF_CANVAS = 2'd2;

	// Rectangle kind bytes.
	localparam logic [7:0] KIND_FILLED  = 8'h52;
	localparam logic [7:0] KIND_OUTLINE = 8'h72;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BGCHAR = 2'd2;

	// Rectangle edges and inner edges (one unit inside), plus the fill flag.
	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] right;
		logic signed [COORD_W-1:0] top;
		logic signed [COORD_W-1:0] bottom;
		logic signed [COORD_W-1:0] left_in;
		logic signed [COORD_W-1:0] right_in;
		logic signed [COORD_W-1:0] top_in;
		logic signed [COORD_W-1:0] bottom_in;
		logic                      filled;
	} bounds_t;

	// A side of zero counts as one, a side beyond the canvas counts as the full side.
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [8:0] v,
			input int unsigned max_side);
		logic [SIDE_W-1:0] ext;
		logic [SIDE_W-1:0] lim;
		ext = SIDE_W'(v);
		lim = SIDE_W'(max_side);
		if (v == 9'd0) begin
			return SIDE_W'(1);
		end else if (ext > lim) begin
			return lim;
		end
		return ext;
	endfunction

endpackage

// File: sv/rcp_cover.sv
// Coverage compare unit of the rectangle canvas painter.
// Decides whether the cell under the sweep lies in the rectangle or its outline band.
// Depends on rcp_pkg.
module rcp_cover import rcp_pkg::*; #(
	parameter int unsigned CW = 8
) (
	input  logic [CW-1:0] col,
	input  logic [CW-1:0] row,
	input  bounds_t       bounds,
	output logic          hit
);

	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;
	logic                      in_rect;
	logic                      near_edge;

	// Cell position in fixed point.
	assign px = $signed(COORD_W'({col, 8'h00}));
	assign py = $signed(COORD_W'({row, 8'h00}));

	// Closed rectangle test and the band less than one unit from an edge.
	assign in_rect = (px >= bounds.left) && (px <= bounds.right) &&
		(py >= bounds.top) && (py <= bounds.bottom);
	assign near_edge = (px < bounds.left_in) || (px > bounds.right_in) ||
		(py < bounds.top_in) || (py > bounds.bottom_in);

	assign hit = in_rect && (bounds.filled || near_edge);

endmodule

// File: sv/rcp_canvas.sv
// Character store of the rectangle canvas painter.
// One write port and one read port with registered read data.
// Depends on rcp_pkg.
module rcp_canvas import rcp_pkg::*; #(
	parameter int unsigned DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF,
	parameter int unsigned AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/rectangle_canvas_painter.sv
// Top level of the rectangle canvas painter: request sequencer, cell sweep and APB registers.
// Depends on rcp_pkg, rcp_cover and rcp_canvas.
//
//   Port group     Direction  Handshake
//   request        in         start, taken when start is high and busy is low
//   result         out        done, one-cycle strobe, no back pressure
//   config (APB)   in/out     psel, penable, pwrite, pready (always high)
//
// A clear or an accepted draw sweeps every cell in use, one cell per cycle, through the
// single coverage compare unit and the one canvas write port, then strobes done. A read
// waits on the registered memory read; a rejected draw, an off-canvas read or an unknown
// request gives done the cycle after it is taken.
// Reset clears the sequencer and the registers (256, 256, 32); the canvas itself holds
// garbage until cleared or drawn. The receiver cannot stall results.
module rectangle_canvas_painter import rcp_pkg::*; #(
	parameter int unsigned MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [7:0]         rect_kind,
	input  logic signed [16:0] rect_left,
	input  logic signed [16:0] rect_top,
	input  logic signed [16:0] rect_width,
	input  logic signed [16:0] rect_height,
	input  logic [7:0]         paint_char,
	input  logic [7:0]         read_col,
	input  logic [7:0]         read_row,
	output logic               done,
	output logic [1:0]         status,
	output logic [7:0]         cell_char,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int unsigned CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SWEEP  = 3'b010,
		ST_RDWAIT = 3'b100
	} state_t;

	state_t            state_q;
	logic [8:0]        width_q;
	logic [8:0]        height_q;
	logic [7:0]        bgchar_q;
	logic [CW-1:0]     col_q;
	logic [CW-1:0]     row_q;
	logic [CW-1:0]     col_last_q;
	logic [CW-1:0]     row_last_q;
	logic [7:0]        paint_q;
	logic              fill_all_q;
	bounds_t           bounds_q;
	bounds_t           bounds_d;
	logic              done_q;
	logic [1:0]        status_q;
	logic [7:0]        cell_char_q;
	logic              accept;
	logic              cfg_wr;
	logic [SIDE_W-1:0] w_eff;
	logic [SIDE_W-1:0] h_eff;
	logic              read_off;
	logic              draw_bad;
	logic              hit;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [7:0]        mem_rdata;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign status    = status_q;
	assign cell_char = cell_char_q;
	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			bgchar_q <= 8'd32;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH:  width_q  <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				REG_BGCHAR: bgchar_q <= pwdata[7:0];
				default:    ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_BGCHAR: prdata = 32'(bgchar_q);
			default:    prdata = 32'd0;
		endcase
	end

	// Request checks and rectangle bounds for the sweep.
	always_comb begin
		w_eff    = clamp_side(width_q, MAX_SIDE);
		h_eff    = clamp_side(height_q, MAX_SIDE);
		read_off = (SIDE_W'(read_col) >= w_eff) || (SIDE_W'(read_row) >= h_eff);
		draw_bad = (rect_width <= 17'sd0) || (rect_height <= 17'sd0) ||
			((rect_kind != KIND_FILLED) && (rect_kind != KIND_OUTLINE));
		bounds_d.left      = COORD_W'(rect_left);
		bounds_d.top       = COORD_W'(rect_top);
		bounds_d.right     = bounds_d.left + COORD_W'(rect_width);
		bounds_d.bottom    = bounds_d.top + COORD_W'(rect_height);
		bounds_d.left_in   = bounds_d.left + COORD_W'(FRAC_ONE);
		bounds_d.top_in    = bounds_d.top + COORD_W'(FRAC_ONE);
		bounds_d.right_in  = bounds_d.right - COORD_W'(FRAC_ONE);
		bounds_d.bottom_in = bounds_d.bottom - COORD_W'(FRAC_ONE);
		bounds_d.filled    = (rect_kind == KIND_FILLED);
	end

	// Sequencer: takes a request, sweeps the canvas or waits on the read, then strobes done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			col_last_q  <= '0;
			row_last_q  <= '0;
			paint_q     <= '0;
			fill_all_q  <= 1'b0;
			bounds_q    <= '0;
			done_q      <= 1'b0;
			status_q    <= STS_OK;
			cell_char_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q      <= '0;
						row_q      <= '0;
						col_last_q <= CW'(w_eff - SIDE_W'(1));
						row_last_q <= CW'(h_eff - SIDE_W'(1));
						case (req_type)
							REQ_CLEAR: begin
								paint_q    <= bgchar_q;
								fill_all_q <= 1'b1;
								state_q    <= ST_SWEEP;
							end
							REQ_DRAW: begin
								if (draw_bad) begin
									done_q      <= 1'b1;
									status_q    <= STS_REJECT;
									cell_char_q <= '0;
								end else begin
									paint_q    <= paint_char;
									fill_all_q <= 1'b0;
									bounds_q   <= bounds_d;
									state_q    <= ST_SWEEP;
								end
							end
							REQ_READ: begin
								if (read_off) begin
									done_q      <= 1'b1;
									status_q    <= STS_OFF_CANVAS;
									cell_char_q <= '0;
								end else begin
									state_q <= ST_RDWAIT;
								end
							end
							default: begin
								done_q      <= 1'b1;
								status_q    <= STS_OK;
								cell_char_q <= '0;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					if (col_q == col_last_q) begin
						col_q <= '0;
						if (row_q == row_last_q) begin
							state_q     <= ST_IDLE;
							done_q      <= 1'b1;
							status_q    <= STS_OK;
							cell_char_q <= '0;
						end else begin
							row_q <= row_q + CW'(1);
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				ST_RDWAIT: begin
					state_q     <= ST_IDLE;
					done_q      <= 1'b1;
					status_q    <= STS_OK;
					cell_char_q <= mem_rdata;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Shared coverage compare for the cell under the sweep.
	rcp_cover #(
		.CW(CW)
	) u_cover (
		.col   (col_q),
		.row   (row_q),
		.bounds(bounds_q),
		.hit   (hit)
	);

	// Canvas store addressing.
	assign mem_we    = (state_q == ST_SWEEP) && (fill_all_q || hit);
	assign mem_waddr = AW'(row_q) * AW'(MAX_SIDE) + AW'(col_q);
	assign mem_re    = accept && (req_type == REQ_READ) && !read_off;
	assign mem_raddr = AW'(CW'(read_row)) * AW'(MAX_SIDE) + AW'(CW'(read_col));

	rcp_canvas #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_canvas (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(paint_q),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// A result never shows while a request is still in work.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while busy");

	// Every taken request either starts work or answers at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("request taken without work or result");

	// Finishing a sweep or a read always gives a result.
	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("work finished without a result");

	// The canvas is written only during a sweep.
	a_write_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_SWEEP))
		else $error("canvas written outside a sweep");

endmodule
